@@ hdl/pki_pkg.sv @@
// Shared types, constants and helper functions of the particle kinematic integrator.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package pki_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int VAL_W         = 32;
    localparam int DT_W          = 16;
    localparam int REQ_W         = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int SUM_W         = 36;
    localparam int AXES          = 3;
    localparam int AXIS_W        = 2;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_ADD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STEP = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MASS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Z = 2'd3;

    // Datapath operations.
    typedef logic [3:0] t_op;
    localparam t_op OP_NONE     = 4'd0;
    localparam t_op OP_LOAD     = 4'd1;
    localparam t_op OP_ADD      = 4'd2;
    localparam t_op OP_SET      = 4'd3;
    localparam t_op OP_DT2      = 4'd4;
    localparam t_op OP_DIV_LOAD = 4'd5;
    localparam t_op OP_DIV_STEP = 4'd6;
    localparam t_op OP_ACC      = 4'd7;
    localparam t_op OP_MUL_ADT  = 4'd8;
    localparam t_op OP_VEL      = 4'd9;
    localparam t_op OP_MUL_VDT  = 4'd10;
    localparam t_op OP_MUL_HALF = 4'd11;
    localparam t_op OP_POS      = 4'd12;
    localparam t_op OP_OUT      = 4'd13;

    typedef struct packed {
        t_op               op;
        logic [AXIS_W-1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic signed [VAL_W-1:0] val;
        logic                    ovf;
    } t_clamp;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {{(SUM_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {{(SUM_W-31){1'b1}}, {31{1'b0}}};

    // Clamps a wide signed sum to 32 bits and reports whether it had to.
    function automatic t_clamp clamp32(input logic signed [SUM_W-1:0] v);
        t_clamp r;
        if (v > SUM_MAX) begin
            r.val = 32'sh7FFF_FFFF;
            r.ovf = 1'b1;
        end else if (v < SUM_MIN) begin
            r.val = 32'sh8000_0000;
            r.ovf = 1'b1;
        end else begin
            r.val = v[VAL_W-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

    // Sign extension of a 32-bit value to the sum width.
    function automatic logic signed [SUM_W-1:0] sext(input logic signed [VAL_W-1:0] v);
        return {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
    endfunction

    // Applies a sign to an unsigned magnitude, result at the sum width.
    function automatic logic signed [SUM_W-1:0] apply_sign(input logic [VAL_W-1:0] mag,
                                                           input logic neg);
        logic signed [SUM_W-1:0] ext;
        ext = {{(SUM_W-VAL_W){1'b0}}, mag};
        return neg ? -ext : ext;
    endfunction

endpackage

@@ hdl/pki_if.sv @@
// Channel interfaces of the particle kinematic integrator: requests, results, configuration.
// Depends on pki_pkg for field widths.
`timescale 1ns / 1ps

interface pki_in_if;
    import pki_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [REQ_W-1:0]        req_type;
    logic signed [VAL_W-1:0] force_x;
    logic signed [VAL_W-1:0] force_y;
    logic signed [VAL_W-1:0] force_z;
    logic [DT_W-1:0]         delta_time;

    modport source (output valid, req_type, force_x, force_y, force_z, delta_time,
                    input ready);
    modport sink   (input valid, req_type, force_x, force_y, force_z, delta_time,
                    output ready);
endinterface

interface pki_out_if;
    import pki_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] pos_x;
    logic signed [VAL_W-1:0] pos_y;
    logic signed [VAL_W-1:0] pos_z;
    logic signed [VAL_W-1:0] vel_x;
    logic signed [VAL_W-1:0] vel_y;
    logic signed [VAL_W-1:0] vel_z;
    logic                    saturated;

    modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, saturated,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, saturated,
                    output ready);
endinterface

interface pki_cfg_if;
    import pki_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [VAL_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/particle_kinematic_integrator.sv @@
// Top level of the particle kinematic integrator: ties the controller and the datapath
// to the request, result and configuration channels. Depends on pki_pkg, pki_if.sv,
// pki_ctrl and pki_dp.
`timescale 1ns / 1ps

// Integrator for one point mass in three axes. Force, velocity and position are
// signed fixed point with FRAC_BITS fraction bits, the mass is unsigned with
// FRAC_BITS fraction bits and delta_time is an unsigned fraction of DT_W bits.
// A request beat adds to or replaces the net force, or advances velocity by a*dt
// and then position by the new velocity times dt plus a*dt*dt/2; every request
// returns one result beat with the position, velocity and a saturation flag. The
// block works on one request at a time. Add and set requests update the net force
// and then move the result into the output register; an unused request code moves
// it there directly. A time step first squares delta_time, then each axis loads a
// restoring divider for a = F/mass that produces one quotient bit per cycle,
// 32 + FRAC_BITS bits in all, followed by three passes through a single shared
// 32x32 multiplier and two saturating sums, and at last the result moves into the
// output register. A new request is taken the cycle after the result has moved
// into the output register; the output register holds a result until the sink
// takes it, and a finished request waits for it to empty. Configuration writes are
// taken at any time but must only be made while no request is in progress; writing
// an initial position also loads that axis of the position.
module particle_kinematic_integrator #(
    parameter int FRAC_BITS = pki_pkg::FRAC_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pki_in_if.sink   i_req,
    pki_out_if.source o_rsp,
    pki_cfg_if.sink  i_cfg
);
    import pki_pkg::*;

    t_cmd                    cmd;
    logic signed [VAL_W-1:0] pos [AXES];
    logic signed [VAL_W-1:0] vel [AXES];
    logic                    saturated;

    pki_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_req_type  (i_req.req_type),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    pki_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_force_x    (i_req.force_x),
        .i_force_y    (i_req.force_y),
        .i_force_z    (i_req.force_z),
        .i_delta_time (i_req.delta_time),
        .o_pos        (pos),
        .o_vel        (vel),
        .o_saturated  (saturated)
    );

    assign i_cfg.ready     = 1'b1;
    assign o_rsp.pos_x     = pos[0];
    assign o_rsp.pos_y     = pos[1];
    assign o_rsp.pos_z     = pos[2];
    assign o_rsp.vel_x     = vel[0];
    assign o_rsp.vel_y     = vel[1];
    assign o_rsp.vel_z     = vel[2];
    assign o_rsp.saturated = saturated;

endmodule

@@ hdl/pki_ctrl.sv @@
// Sequencer of the particle kinematic integrator: handshakes and datapath commands.
// Depends on pki_pkg.
`timescale 1ns / 1ps

module pki_ctrl #(
    parameter int FRAC_BITS = pki_pkg::FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [pki_pkg::REQ_W-1:0] i_req_type,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output pki_pkg::t_cmd             o_cmd
);
    import pki_pkg::*;

    localparam int DIV_W = VAL_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DIV_W);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ADD      = 4'd1;
    localparam logic [3:0] S_SET      = 4'd2;
    localparam logic [3:0] S_DT2      = 4'd3;
    localparam logic [3:0] S_DIV_LOAD = 4'd4;
    localparam logic [3:0] S_DIV      = 4'd5;
    localparam logic [3:0] S_ACC      = 4'd6;
    localparam logic [3:0] S_MUL_ADT  = 4'd7;
    localparam logic [3:0] S_VEL      = 4'd8;
    localparam logic [3:0] S_MUL_VDT  = 4'd9;
    localparam logic [3:0] S_MUL_HALF = 4'd10;
    localparam logic [3:0] S_POS      = 4'd11;
    localparam logic [3:0] S_DONE     = 4'd12;

    localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);

    logic [3:0]        r_state, n_state;
    logic [AXIS_W-1:0] r_axis, n_axis;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    t_op               op;

    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        op          = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    op = OP_LOAD;
                    unique case (i_req_type)
                        REQ_ADD:  n_state = S_ADD;
                        REQ_SET:  n_state = S_SET;
                        REQ_STEP: n_state = S_DT2;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_ADD: begin
                op      = OP_ADD;
                n_state = S_DONE;
            end
            S_SET: begin
                op      = OP_SET;
                n_state = S_DONE;
            end
            S_DT2: begin
                op      = OP_DT2;
                n_axis  = '0;
                n_state = S_DIV_LOAD;
            end
            S_DIV_LOAD: begin
                op      = OP_DIV_LOAD;
                n_cnt   = CNT_W'(DIV_W - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                // One quotient bit per cycle.
                op    = OP_DIV_STEP;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                op      = OP_ACC;
                n_state = S_MUL_ADT;
            end
            S_MUL_ADT: begin
                op      = OP_MUL_ADT;
                n_state = S_VEL;
            end
            S_VEL: begin
                op      = OP_VEL;
                n_state = S_MUL_VDT;
            end
            S_MUL_VDT: begin
                op      = OP_MUL_VDT;
                n_state = S_MUL_HALF;
            end
            S_MUL_HALF: begin
                op      = OP_MUL_HALF;
                n_state = S_POS;
            end
            S_POS: begin
                op = OP_POS;
                if (r_axis == LAST_AXIS) begin
                    n_state = S_DONE;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = S_DIV_LOAD;
                end
            end
            S_DONE: begin
                // The result register takes the new beat once the old one has left.
                if (!r_out_valid || i_out_ready) begin
                    op          = OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd.op    = op;
    assign o_cmd.axis  = r_axis;

endmodule

@@ hdl/pki_dp.sv @@
// Datapath of the particle kinematic integrator: motion state, restoring divider,
// shared 32x32 multiplier and result register. Depends on pki_pkg.
`timescale 1ns / 1ps

module pki_dp #(
    parameter int FRAC_BITS = pki_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pki_pkg::t_cmd                 i_cmd,
    input  logic                          i_cfg_we,
    input  logic [pki_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pki_pkg::VAL_W-1:0]     i_cfg_data,
    input  logic signed [pki_pkg::VAL_W-1:0] i_force_x,
    input  logic signed [pki_pkg::VAL_W-1:0] i_force_y,
    input  logic signed [pki_pkg::VAL_W-1:0] i_force_z,
    input  logic [pki_pkg::DT_W-1:0]      i_delta_time,
    output logic signed [pki_pkg::VAL_W-1:0] o_pos [pki_pkg::AXES],
    output logic signed [pki_pkg::VAL_W-1:0] o_vel [pki_pkg::AXES],
    output logic                          o_saturated
);
    import pki_pkg::*;

    localparam int DIV_W = VAL_W + FRAC_BITS;
    localparam logic [DIV_W-1:0] Q_POS_MAX = DIV_W'(32'h7FFF_FFFF);
    localparam logic [DIV_W-1:0] Q_NEG_MAX = DIV_W'(32'h8000_0000);
    localparam logic [VAL_W-1:0] MASS_ONE  = VAL_W'(1) << FRAC_BITS;

    // Architectural state.
    logic [VAL_W-1:0]        r_mass;
    logic signed [VAL_W-1:0] r_force [AXES];
    logic signed [VAL_W-1:0] r_vel   [AXES];
    logic signed [VAL_W-1:0] r_pos   [AXES];

    // Working registers of one request.
    logic signed [VAL_W-1:0] r_fin [AXES];
    logic [DT_W-1:0]         r_dt;
    logic [2*DT_W-1:0]       r_dt2;
    logic [DIV_W-1:0]        r_quo;
    logic [VAL_W-1:0]        r_rem;
    logic [VAL_W-1:0]        r_acc_mag;
    logic                    r_acc_neg;
    logic [2*VAL_W-1:0]      r_prod;
    logic                    r_prod_neg;
    logic signed [SUM_W-1:0] r_vdt;
    logic                    r_sat;

    // Result register.
    logic signed [VAL_W-1:0] r_out_pos [AXES];
    logic signed [VAL_W-1:0] r_out_vel [AXES];
    logic                    r_out_sat;

    logic signed [VAL_W-1:0] f_cur, v_cur, p_cur;
    logic [VAL_W-1:0]        f_mag, v_mag;
    logic                    f_neg, v_neg;
    logic [VAL_W:0]          trial, diff;
    logic                    ge;
    logic [VAL_W-1:0]        rem_next;
    logic [VAL_W-1:0]        mul_a, mul_b;
    logic [2*VAL_W-1:0]      mul_p;
    logic [VAL_W-1:0]        acc_mag;
    logic                    acc_neg, acc_sat;
    logic signed [SUM_W-1:0] dv, vdt, half;
    t_clamp                  vel_c, pos_c;
    t_clamp                  add_c [AXES];

    assign f_cur = r_force[i_cmd.axis];
    assign v_cur = r_vel[i_cmd.axis];
    assign p_cur = r_pos[i_cmd.axis];
    assign f_neg = f_cur[VAL_W-1];
    assign v_neg = v_cur[VAL_W-1];
    assign f_mag = f_neg ? VAL_W'(-f_cur) : VAL_W'(f_cur);
    assign v_mag = v_neg ? VAL_W'(-v_cur) : VAL_W'(v_cur);

    // Restoring division step: shift in the next dividend bit, subtract if it fits.
    assign trial    = {r_rem, r_quo[DIV_W-1]};
    assign ge       = trial >= {1'b0, r_mass};
    assign diff     = trial - {1'b0, r_mass};
    assign rem_next = ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];

    // Acceleration from the quotient, with the zero-mass and overflow cases.
    always_comb begin
        acc_mag = r_quo[VAL_W-1:0];
        acc_neg = f_neg;
        acc_sat = 1'b0;
        if (r_mass == '0) begin
            if (f_cur == '0) begin
                acc_mag = '0;
                acc_neg = 1'b0;
            end else begin
                acc_mag = f_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                acc_sat = 1'b1;
            end
        end else if (f_neg) begin
            if (r_quo > Q_NEG_MAX) begin
                acc_mag = 32'h8000_0000;
                acc_sat = 1'b1;
            end
        end else if (r_quo > Q_POS_MAX) begin
            acc_mag = 32'h7FFF_FFFF;
            acc_sat = 1'b1;
        end
    end

    // Shared multiplier on magnitudes; the sign travels beside the product.
    always_comb begin
        unique case (i_cmd.op)
            OP_MUL_ADT: begin
                mul_a = r_acc_mag;
                mul_b = {{(VAL_W-DT_W){1'b0}}, r_dt};
            end
            OP_MUL_VDT: begin
                mul_a = v_mag;
                mul_b = {{(VAL_W-DT_W){1'b0}}, r_dt};
            end
            OP_MUL_HALF: begin
                mul_a = r_acc_mag;
                mul_b = r_dt2;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = {{VAL_W{1'b0}}, mul_a} * {{VAL_W{1'b0}}, mul_b};

    assign dv    = apply_sign(r_prod[DT_W +: VAL_W], r_prod_neg);
    assign vdt   = apply_sign(r_prod[DT_W +: VAL_W], r_prod_neg);
    // The half term drops 2*DT_W+1 bits of a*dt*dt.
    assign half  = apply_sign({1'b0, r_prod[2*VAL_W-1:2*DT_W+1]}, r_prod_neg);
    assign vel_c = clamp32(sext(v_cur) + dv);
    assign pos_c = clamp32(sext(p_cur) + r_vdt + half);

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            add_c[i] = clamp32(sext(r_force[i]) + sext(r_fin[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass <= MASS_ONE;
            for (int i = 0; i < AXES; i++) begin
                r_force[i] <= '0;
                r_vel[i]   <= '0;
                r_pos[i]   <= '0;
            end
        end else begin
            unique case (i_cmd.op)
                OP_ADD: begin
                    for (int i = 0; i < AXES; i++) begin
                        r_force[i] <= add_c[i].val;
                    end
                end
                OP_SET: begin
                    for (int i = 0; i < AXES; i++) begin
                        r_force[i] <= r_fin[i];
                    end
                end
                OP_VEL:  r_vel[i_cmd.axis] <= vel_c.val;
                OP_POS:  r_pos[i_cmd.axis] <= pos_c.val;
                default: ;
            endcase
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_MASS:  r_mass   <= i_cfg_data;
                    REG_POS_X: r_pos[0] <= i_cfg_data;
                    REG_POS_Y: r_pos[1] <= i_cfg_data;
                    REG_POS_Z: r_pos[2] <= i_cfg_data;
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                OP_LOAD: r_sat <= 1'b0;
                OP_ADD:  r_sat <= r_sat | add_c[0].ovf | add_c[1].ovf | add_c[2].ovf;
                OP_ACC:  r_sat <= r_sat | acc_sat;
                OP_VEL:  r_sat <= r_sat | vel_c.ovf;
                OP_POS:  r_sat <= r_sat | pos_c.ovf;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_fin[0] <= i_force_x;
                r_fin[1] <= i_force_y;
                r_fin[2] <= i_force_z;
                r_dt     <= i_delta_time;
            end
            OP_DT2: r_dt2 <= {{DT_W{1'b0}}, r_dt} * {{DT_W{1'b0}}, r_dt};
            OP_DIV_LOAD: begin
                r_rem <= '0;
                r_quo <= {f_mag, {FRAC_BITS{1'b0}}};
            end
            OP_DIV_STEP: begin
                r_rem <= rem_next;
                r_quo <= {r_quo[DIV_W-2:0], ge};
            end
            OP_ACC: begin
                r_acc_mag <= acc_mag;
                r_acc_neg <= acc_neg;
            end
            OP_MUL_ADT: begin
                r_prod     <= mul_p;
                r_prod_neg <= r_acc_neg;
            end
            OP_MUL_VDT: begin
                r_prod     <= mul_p;
                r_prod_neg <= v_neg;
            end
            OP_MUL_HALF: begin
                // v*dt leaves the product register as a*dt*dt enters it.
                r_vdt      <= vdt;
                r_prod     <= mul_p;
                r_prod_neg <= r_acc_neg;
            end
            OP_OUT: begin
                for (int i = 0; i < AXES; i++) begin
                    r_out_pos[i] <= r_pos[i];
                    r_out_vel[i] <= r_vel[i];
                end
                r_out_sat <= r_sat;
            end
            default: ;
        endcase
    end

    assign o_pos       = r_out_pos;
    assign o_vel       = r_out_vel;
    assign o_saturated = r_out_sat;

endmodule
